// ===== hw/rtl/pvenc_pkg.sv =====
// shared types and constants of the prefix varint encoder
package pvenc_pkg;

    localparam int unsigned MAX_BYTES = 10;
    localparam int unsigned CNT_W     = 4;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_NULL_TAG     = 2'd0;
    localparam logic [1:0] CFG_SIGNED_TAG   = 2'd1;
    localparam logic [1:0] CFG_UNSIGNED_TAG = 2'd2;

    // request type codes
    localparam logic [1:0] REQ_RAW_UNSIGNED    = 2'd0;
    localparam logic [1:0] REQ_RAW_SIGNED      = 2'd1;
    localparam logic [1:0] REQ_TAGGED_UNSIGNED = 2'd2;
    localparam logic [1:0] REQ_TAGGED_SIGNED   = 2'd3;

    // marker bytes of the long forms
    localparam logic [7:0] MARK_NARROW = 8'hF0;
    localparam logic [7:0] MARK_WIDE   = 8'hF4;

    // one classified request: encoded bytes left-aligned, first byte at the top
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] enc;
        logic [CNT_W-1:0]       cnt;
    } t_job;

endpackage

// ===== hw/rtl/pvenc_front.sv =====
// front end: tag registers, request accept and classification into byte strings
module pvenc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_req_type,
    input  logic                 i_wide,
    input  logic [63:0]          i_value,
    input  logic                 i_q_full,
    output logic                 o_push,
    output pvenc_pkg::t_job      o_job
);
    import pvenc_pkg::*;

    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;
    localparam logic [2:0] LEN_LONG = 3'd0;

    logic [7:0]  r_null_tag;
    logic [7:0]  r_signed_tag;
    logic [7:0]  r_unsigned_tag;

    logic        w_signed;
    logic        w_tagged;
    logic [63:0] w_u;
    logic        w_fit7, w_fit14, w_fit21, w_fit28;
    logic [2:0]  w_len;
    logic [71:0] w_vbytes;
    logic [3:0]  w_vcnt;
    logic [7:0]  w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_tag     <= 8'd0;
            r_signed_tag   <= 8'd0;
            r_unsigned_tag <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NULL_TAG:     r_null_tag     <= i_cfg_data;
                CFG_SIGNED_TAG:   r_signed_tag   <= i_cfg_data;
                CFG_UNSIGNED_TAG: r_unsigned_tag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_req_type)
            REQ_RAW_UNSIGNED:    begin w_signed = 1'b0; w_tagged = 1'b0; end
            REQ_RAW_SIGNED:      begin w_signed = 1'b1; w_tagged = 1'b0; end
            REQ_TAGGED_UNSIGNED: begin w_signed = 1'b0; w_tagged = 1'b1; end
            REQ_TAGGED_SIGNED:   begin w_signed = 1'b1; w_tagged = 1'b1; end
            default:             begin w_signed = 1'b0; w_tagged = 1'b0; end
        endcase
    end

    // narrow operands are zero- or sign-extended from bit 31
    assign w_u = i_wide ? i_value
                        : {{32{w_signed & i_value[31]}}, i_value[31:0]};

    // signed fit: all bits from the sign position up are equal
    always_comb begin
        if (w_signed) begin
            w_fit7  = (&w_u[63:6])  | ~(|w_u[63:6]);
            w_fit14 = (&w_u[63:13]) | ~(|w_u[63:13]);
            w_fit21 = (&w_u[63:20]) | ~(|w_u[63:20]);
            w_fit28 = (&w_u[63:27]) | ~(|w_u[63:27]);
        end else begin
            w_fit7  = ~(|w_u[63:7]);
            w_fit14 = ~(|w_u[63:14]);
            w_fit21 = ~(|w_u[63:21]);
            w_fit28 = ~(|w_u[63:28]);
        end
    end

    always_comb begin
        if (w_fit7)       w_len = LEN_1;
        else if (w_fit14) w_len = LEN_2;
        else if (w_fit21) w_len = LEN_3;
        else if (w_fit28) w_len = LEN_4;
        else              w_len = LEN_LONG;
    end

    always_comb begin
        unique case (w_len)
            LEN_1: begin
                w_vbytes = {1'b0, w_u[6:0], 64'd0};
                w_vcnt   = 4'd1;
            end
            LEN_2: begin
                w_vbytes = {2'b10, w_u[13:0], 56'd0};
                w_vcnt   = 4'd2;
            end
            LEN_3: begin
                w_vbytes = {3'b110, w_u[20:0], 48'd0};
                w_vcnt   = 4'd3;
            end
            LEN_4: begin
                w_vbytes = {4'b1110, w_u[27:0], 40'd0};
                w_vcnt   = 4'd4;
            end
            default: begin
                if (i_wide) begin
                    w_vbytes = {MARK_WIDE, w_u};
                    w_vcnt   = 4'd9;
                end else begin
                    w_vbytes = {MARK_NARROW, w_u[31:0], 32'd0};
                    w_vcnt   = 4'd5;
                end
            end
        endcase
    end

    assign w_tag = w_signed ? r_signed_tag : r_unsigned_tag;

    always_comb begin
        if (!w_tagged) begin
            o_job.enc = {w_vbytes, 8'd0};
            o_job.cnt = w_vcnt;
        end else if (w_u == 64'd0) begin
            o_job.enc = {r_null_tag, 72'd0};
            o_job.cnt = 4'd1;
        end else begin
            o_job.enc = {w_tag, w_vbytes};
            o_job.cnt = w_vcnt + 4'd1;
        end
    end

    assign o_ready = ~i_q_full;
    assign o_push  = i_valid & ~i_q_full;

endmodule

// ===== hw/rtl/pvenc_queue.sv =====
// short queue of classified requests between front and back end
module pvenc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pvenc_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pvenc_pkg::t_job o_job
);
    import pvenc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/pvenc_back.sv =====
// back end: shifts the current byte string out through the output register
module pvenc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  pvenc_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import pvenc_pkg::*;

    localparam int unsigned BW = MAX_BYTES * 8;

    logic [BW-1:0]    r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;

    logic             w_move;
    logic             w_load;

    // a byte moves when the output register is free or being drained
    assign w_move = (r_cnt != '0) && (!r_valid || i_ready);
    // next string is loaded as the last byte of the current one leaves
    assign w_load = i_q_valid && ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_move));
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= i_job.enc;
        end else if (w_move) begin
            r_buf <= {r_buf[BW-9:0], 8'd0};
        end
        if (w_move) begin
            r_byte <= r_buf[BW-1:BW-8];
            r_last <= (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_cnt <= i_job.cnt;
            end else if (w_move) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_move) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

// ===== hw/rtl/prefix_varint_encoder.sv =====
// top level of the prefix-length varint encoder
// usage:
//   requests enter on i_valid/o_ready with i_req_type, i_wide and i_value;
//   encoded bytes leave on o_valid/i_ready as o_out_byte, o_last marking
//   the final byte of each request (1 to 10 bytes per request)
//   tag bytes are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle
// timing:
//   the front end classifies a request in the cycle it is accepted and
//   stores the whole byte string in a queue of QUEUE_DEPTH entries
//   the first byte appears once the string has passed through the queue
//   and the back-end buffer into the output register; the back end sends
//   one byte per cycle while i_ready is high; strings follow each other without gaps
//   a new request is taken every cycle while the queue has room
// reset:
//   synchronous, active low; empties queue and output, clears tags to zero
// stalls:
//   with i_ready low the output byte holds, the back end and then the
//   queue fill, and o_ready falls once the queue is full
module prefix_varint_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_wide,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import pvenc_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_job w_in_job;
    t_job w_out_job;

    pvenc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_wide     (i_wide),
        .i_value    (i_value),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_in_job)
    );

    pvenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_out_job)
    );

    pvenc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_out_job),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
